### rtl/sns_pkg.sv
package sns_pkg;

  localparam int unsigned MAX_BINS_DEF     = 1024;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned BIN_W   = 10;
  localparam int unsigned LOG_W   = 24;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned MUL_W   = 32;
  localparam int unsigned DIV_NW  = 48;
  localparam int unsigned DIV_DW  = 32;
  localparam int unsigned ROOT_W  = 22;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned RND_SH  = 40;
  localparam int unsigned OUT_TW  = ((BIN_W + 2 * LOG_W + 1 + 7) / 8) * 8;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [ROOT_W-1:0] CBRT_MAX = 22'd2642245;
  localparam logic [MUL_W-1:0]  LN2_Q32  = 32'hB17217F8;
  localparam logic [LOG_W-1:0]  LOG_MAX  = 24'hFFFFFF;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_LOW_BIN  = 2'd0;
  localparam logic [1:0] REG_HIGH_BIN = 2'd1;
  localparam logic [1:0] REG_MIN_HALF = 2'd2;

  typedef struct packed {
    logic [9:0]  low_bin;
    logic [10:0] high_bin;
    logic [9:0]  min_half_band;
  } cfg_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [LOG_W-1:0] suppressed;
    logic [LOG_W-1:0] noise_level;
    logic             saturated;
  } res_t;

endpackage

### rtl/sns_mul.sv
module sns_mul (
  input  logic                           clk_i,
  input  logic [sns_pkg::MUL_W-1:0]      a_i,
  input  logic [sns_pkg::MUL_W-1:0]      b_i,
  output logic [2*sns_pkg::MUL_W-1:0]    p_o
);
  import sns_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
  end

  assign p_o = p_q;

endmodule

### rtl/sns_div.sv
module sns_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sns_pkg::DIV_NW-1:0]   num_i,
  input  logic [sns_pkg::DIV_DW-1:0]   den_i,
  output logic                         done_o,
  output logic [sns_pkg::DIV_NW-1:0]   quo_o
);
  import sns_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_NW);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW:0]   trial;
  logic              qbit;
  logic [DIV_DW-1:0] rem_d;

  // restoring division, one quotient bit a cycle
  always_comb begin
    trial = {rem_q, quo_q[DIV_NW-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? DIV_DW'(trial - {1'b0, den_q}) : trial[DIV_DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_NW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/sns_core.sv
module sns_core #(
  parameter int unsigned MAX_BINS     = sns_pkg::MAX_BINS_DEF,
  parameter int unsigned SAMPLE_WIDTH = sns_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sns_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_mode_i,
  input  logic [SAMPLE_WIDTH-1:0]     in_mag_i,
  input  logic                        in_last_i,
  input  logic [sns_pkg::BIN_W-1:0]   in_bin_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output sns_pkg::res_t               res_o
);
  import sns_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_BINS);
  localparam int unsigned CW   = $clog2(MAX_BINS + 1);
  localparam int unsigned LW   = (CW > 11) ? CW : 11;
  localparam int unsigned PW   = LOG_W + CW;
  localparam int unsigned SUMW = ROOT_W + CW;
  localparam int unsigned XW   = (SAMPLE_WIDTH > MAG_W) ? SAMPLE_WIDTH : MAG_W + 1;
  localparam int unsigned BXW  = (BIN_W > AW) ? BIN_W : AW;
  localparam int unsigned VW   = DIV_NW + 1;
  localparam int unsigned CUW  = 3 * ROOT_W;

  typedef enum logic [26:0] {
    ST_IDLE    = 27'd1 << 0,
    ST_RD_OUT  = 27'd1 << 1,
    ST_A_INIT  = 27'd1 << 2,
    ST_A_CHK   = 27'd1 << 3,
    ST_CR_SQ   = 27'd1 << 4,
    ST_CR_HI   = 27'd1 << 5,
    ST_CR_LO   = 27'd1 << 6,
    ST_CR_CMP  = 27'd1 << 7,
    ST_M_WAIT  = 27'd1 << 8,
    ST_B_INIT  = 27'd1 << 9,
    ST_B_CHK   = 27'd1 << 10,
    ST_B_RD    = 27'd1 << 11,
    ST_B_DIV   = 27'd1 << 12,
    ST_B_NORM  = 27'd1 << 13,
    ST_L_SQ    = 27'd1 << 14,
    ST_L_RED   = 27'd1 << 15,
    ST_L_SCALE = 27'd1 << 16,
    ST_L_RND   = 27'd1 << 17,
    ST_B_WR    = 27'd1 << 18,
    ST_C_CHK   = 27'd1 << 19,
    ST_C_BND   = 27'd1 << 20,
    ST_C_RD0   = 27'd1 << 21,
    ST_C_RD1   = 27'd1 << 22,
    ST_C_SUB   = 27'd1 << 23,
    ST_C_DIV   = 27'd1 << 24,
    ST_C_WR    = 27'd1 << 25,
    ST_SPARE   = 27'd1 << 26
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q;
  logic [LW-1:0]     i_q;
  logic [SUMW-1:0]   sum_q;
  logic [ROOT_W-1:0] r_q;
  logic [4:0]        bit_q;
  logic [2*ROOT_W-1:0] tt_q;
  logic [2*ROOT_W-1:0] hi_q;
  logic              cube_g_q;
  logic [ROOT_W-1:0] m_q;
  logic [MAG_W-1:0]  g_q;
  logic              gsat_q;
  logic [VW-1:0]     v_q;
  logic [5:0]        p_q;
  logic [MUL_W-1:0]  z_q;
  logic [FRAC_W-1:0] frac_q;
  logic [4:0]        k_q;
  logic [LOG_W-1:0]  y_q;
  logic              s_q;
  logic [PW-1:0]     psum_q;
  logic [LW-1:0]     hu_q;
  logic [1:0]        hr_q;
  logic [LW-1:0]     hup_q;
  logic [LW:0]       hop_q;
  logic [LW-1:0]     beg_q;
  logic [LW-1:0]     end_q;
  logic [PW-1:0]     pe_q;
  logic [LOG_W-1:0]  nz_q;
  logic [BIN_W-1:0]  hb_q;
  logic              hin_q;

  logic [MAG_W-1:0]  spec_mem  [MAX_BINS];
  logic [LOG_W-1:0]  log_mem   [MAX_BINS];
  logic [LOG_W-1:0]  noise_mem [MAX_BINS];
  logic              sat_mem   [MAX_BINS];
  logic [PW-1:0]     pre_mem   [MAX_BINS+1];
  logic [MAG_W-1:0]  spec_rd_q;
  logic [LOG_W-1:0]  log_rd_q;
  logic [LOG_W-1:0]  noise_rd_q;
  logic              sat_rd_q;
  logic [PW-1:0]     pre_rd_q;

  logic              acc;
  logic              host_rd;
  logic              spec_we;
  logic [XW-1:0]     mag_ext;
  logic [MAG_W-1:0]  mag_x;
  logic [BXW-1:0]    bin_ext;
  logic              bin_ok;
  logic              band_ok;
  logic              a_more;
  logic              b_more;
  logic [ROOT_W-1:0] t_val;
  logic [ROOT_W-1:0] cube_t;
  logic [CUW-1:0]    cube;
  logic [ROOT_W-1:0] r_new;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic [MUL_W:0]    zz;
  logic [2*MUL_W:0]  rnd;
  logic [LOG_W-1:0]  y_rnd;
  logic [LW:0]       ho;
  logic [LW+1:0]     e_sum;
  logic [CW-1:0]     nm1;
  logic [2:0]        hr2;
  logic [CW-1:0]     pre_wa;
  logic [PW-1:0]     pre_wd;
  logic              pre_we;
  logic [LOG_W-1:0]  ry, rn;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign host_rd    = acc && in_mode_i;
  assign spec_we    = acc && !in_mode_i && (32'(cnt_q) < MAX_BINS);

  // wide samples clamp to the 32-bit magnitude range
  assign mag_ext = XW'(in_mag_i);
  assign mag_x   = (|mag_ext[XW-1:MAG_W]) ? '1 : mag_ext[MAG_W-1:0];
  assign bin_ext = BXW'(in_bin_i);
  assign bin_ok  = (32'(in_bin_i) < MAX_BINS);

  assign band_ok = (11'(cfg_i.low_bin) < cfg_i.high_bin);
  assign a_more  = (i_q < LW'(cfg_i.high_bin)) && (i_q < LW'(cnt_q));
  assign b_more  = (i_q < LW'(cnt_q));

  assign t_val  = r_q | (ROOT_W'(1) << bit_q);
  assign cube_t = cube_g_q ? m_q : t_val;
  assign cube   = {hi_q, {ROOT_W{1'b0}}} + CUW'(mul_p[2*ROOT_W-1:0]);
  assign r_new  = (cube <= CUW'({spec_rd_q, 32'b0})) ? t_val : r_q;

  assign zz    = mul_p[2*MUL_W-1:MUL_W-1];
  assign rnd   = {1'b0, mul_p} + ((2*MUL_W+1)'(1) << (RND_SH - 1));
  assign y_rnd = rnd[2*MUL_W] ? LOG_MAX : rnd[RND_SH +: LOG_W];

  assign ho    = (LW+1)'(i_q) + (LW+1)'(i_q >> 1);
  assign e_sum = (LW+2)'(i_q) + (LW+2)'(hop_q);
  assign nm1   = cnt_q - CW'(1);
  assign hr2   = 3'(hr_q) + 3'd2;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_CR_SQ: begin
        mul_a = MUL_W'(cube_t);
        mul_b = MUL_W'(cube_t);
      end
      ST_CR_HI: begin
        mul_a = MUL_W'(mul_p[2*ROOT_W-1:ROOT_W]);
        mul_b = MUL_W'(cube_t);
      end
      ST_CR_LO: begin
        mul_a = MUL_W'(tt_q[ROOT_W-1:0]);
        mul_b = MUL_W'(cube_t);
      end
      ST_L_SQ: begin
        mul_a = z_q;
        mul_b = z_q;
      end
      ST_L_SCALE: begin
        mul_a = MUL_W'({p_q - 6'd16, frac_q});
        mul_b = LN2_Q32;
      end
      default: ;
    endcase
  end

  // shared divider operands
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_q)
      ST_A_CHK: begin
        div_start = !a_more;
        div_num   = DIV_NW'(sum_q);
        div_den   = DIV_DW'(cfg_i.high_bin) - DIV_DW'(cfg_i.low_bin) + DIV_DW'(1);
      end
      ST_B_RD: begin
        div_start = (g_q != '0);
        div_num   = {spec_rd_q, 16'b0};
        div_den   = g_q;
      end
      ST_C_SUB: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(pe_q - pre_rd_q);
        div_den   = DIV_DW'(end_q - beg_q);
      end
      default: ;
    endcase
  end

  sns_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  sns_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_mode_i) state_d = ST_RD_OUT;
          else if (in_last_i) state_d = ST_A_INIT;
        end
      end
      ST_RD_OUT:  if (res_ready_i) state_d = ST_IDLE;
      ST_A_INIT:  state_d = band_ok ? ST_A_CHK : ST_B_INIT;
      ST_A_CHK:   state_d = a_more ? ST_CR_SQ : ST_M_WAIT;
      ST_CR_SQ:   state_d = ST_CR_HI;
      ST_CR_HI:   state_d = ST_CR_LO;
      ST_CR_LO:   state_d = ST_CR_CMP;
      ST_CR_CMP: begin
        if (cube_g_q) state_d = ST_B_INIT;
        else if (bit_q == '0) state_d = ST_A_CHK;
        else state_d = ST_CR_SQ;
      end
      ST_M_WAIT: begin
        if (div_done) state_d = (div_quo > DIV_NW'(CBRT_MAX)) ? ST_B_INIT : ST_CR_SQ;
      end
      ST_B_INIT:  state_d = ST_B_CHK;
      ST_B_CHK:   state_d = b_more ? ST_B_RD : ST_C_CHK;
      ST_B_RD:    state_d = (g_q == '0) ? ST_B_WR : ST_B_DIV;
      ST_B_DIV:   if (div_done) state_d = ST_B_NORM;
      ST_B_NORM:  if (v_q[VW-1]) state_d = ST_L_SQ;
      ST_L_SQ:    state_d = ST_L_RED;
      ST_L_RED:   state_d = (k_q == 5'(FRAC_W - 1)) ? ST_L_SCALE : ST_L_SQ;
      ST_L_SCALE: state_d = ST_L_RND;
      ST_L_RND:   state_d = ST_B_WR;
      ST_B_WR:    state_d = ST_B_CHK;
      ST_C_CHK:   state_d = b_more ? ST_C_BND : ST_IDLE;
      ST_C_BND:   state_d = ST_C_RD0;
      ST_C_RD0:   state_d = (end_q > beg_q) ? ST_C_RD1 : ST_C_WR;
      ST_C_RD1:   state_d = ST_C_SUB;
      ST_C_SUB:   state_d = ST_C_DIV;
      ST_C_DIV:   if (div_done) state_d = ST_C_WR;
      ST_C_WR:    state_d = ST_C_CHK;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (spec_we) cnt_q <= cnt_q + CW'(1);
      else if (state_q == ST_C_CHK && !b_more) cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (host_rd) begin
          hb_q  <= in_bin_i;
          hin_q <= bin_ok;
        end
      end
      ST_A_INIT: begin
        i_q    <= LW'(cfg_i.low_bin);
        sum_q  <= '0;
        gsat_q <= 1'b0;
        if (!band_ok) g_q <= '0;
      end
      ST_A_CHK: begin
        r_q      <= '0;
        bit_q    <= 5'(ROOT_W - 1);
        cube_g_q <= 1'b0;
      end
      ST_CR_HI: tt_q <= mul_p[2*ROOT_W-1:0];
      ST_CR_LO: hi_q <= mul_p[2*ROOT_W-1:0];
      ST_CR_CMP: begin
        if (cube_g_q) begin
          g_q <= cube[2*MAG_W-1:MAG_W];
        end else begin
          r_q <= r_new;
          if (bit_q == '0) begin
            sum_q <= sum_q + SUMW'(r_new);
            i_q   <= i_q + LW'(1);
          end else begin
            bit_q <= bit_q - 5'd1;
          end
        end
      end
      ST_M_WAIT: begin
        if (div_done) begin
          if (div_quo > DIV_NW'(CBRT_MAX)) begin
            g_q    <= '1;
            gsat_q <= 1'b1;
          end else begin
            m_q      <= div_quo[ROOT_W-1:0];
            cube_g_q <= 1'b1;
          end
        end
      end
      ST_B_INIT: begin
        psum_q <= '0;
        i_q    <= '0;
      end
      ST_B_CHK: begin
        if (!b_more) begin
          i_q  <= '0;
          hu_q <= '0;
          hr_q <= '0;
        end
      end
      ST_B_RD: begin
        // zero level: any nonzero bin pegs the log
        if (g_q == '0) begin
          y_q <= (spec_rd_q != '0) ? LOG_MAX : '0;
          s_q <= gsat_q | (spec_rd_q != '0);
        end
      end
      ST_B_DIV: begin
        if (div_done) begin
          v_q <= VW'(div_quo) + (VW'(1) << 16);
          p_q <= 6'(VW - 1);
        end
      end
      ST_B_NORM: begin
        if (v_q[VW-1]) begin
          z_q    <= v_q[VW-1 -: MUL_W];
          k_q    <= '0;
          frac_q <= '0;
        end else begin
          v_q <= v_q << 1;
          p_q <= p_q - 6'd1;
        end
      end
      ST_L_RED: begin
        z_q    <= zz[MUL_W] ? zz[MUL_W:1] : zz[MUL_W-1:0];
        frac_q <= {frac_q[FRAC_W-2:0], zz[MUL_W]};
        k_q    <= k_q + 5'd1;
      end
      ST_L_RND: begin
        y_q <= y_rnd;
        s_q <= gsat_q | (y_rnd == LOG_MAX);
      end
      ST_B_WR: begin
        psum_q <= psum_q + PW'(y_q);
        i_q    <= i_q + LW'(1);
      end
      ST_C_CHK: begin
        hup_q <= (hu_q < LW'(cfg_i.min_half_band)) ? LW'(cfg_i.min_half_band) : hu_q;
        hop_q <= (ho < (LW+1)'(cfg_i.min_half_band)) ? (LW+1)'(cfg_i.min_half_band) : ho;
      end
      ST_C_BND: begin
        beg_q <= (i_q > hup_q) ? i_q - hup_q : '0;
        end_q <= (e_sum > (LW+2)'(nm1)) ? LW'(nm1) : LW'(e_sum);
      end
      ST_C_RD0: if (!(end_q > beg_q)) nz_q <= '0;
      ST_C_RD1: pe_q <= pre_rd_q;
      ST_C_DIV: if (div_done) nz_q <= div_quo[LOG_W-1:0];
      ST_C_WR: begin
        i_q <= i_q + LW'(1);
        // floor(2i/3) kept as quotient and remainder
        if (hr2 >= 3'd3) begin
          hu_q <= hu_q + LW'(1);
          hr_q <= 2'(hr2 - 3'd3);
        end else begin
          hr_q <= 2'(hr2);
        end
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (spec_we) spec_mem[cnt_q[AW-1:0]] <= mag_x;
    if (state_q == ST_A_CHK || state_q == ST_B_CHK) spec_rd_q <= spec_mem[i_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_B_WR) begin
      log_mem[i_q[AW-1:0]] <= y_q;
      sat_mem[i_q[AW-1:0]] <= s_q;
    end
    if (host_rd) begin
      log_rd_q <= log_mem[bin_ext[AW-1:0]];
      sat_rd_q <= sat_mem[bin_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_C_WR) noise_mem[i_q[AW-1:0]] <= nz_q;
    if (host_rd) noise_rd_q <= noise_mem[bin_ext[AW-1:0]];
  end

  assign pre_we = (state_q == ST_B_INIT) || (state_q == ST_B_WR);
  assign pre_wa = (state_q == ST_B_INIT) ? '0 : CW'(i_q + LW'(1));
  assign pre_wd = (state_q == ST_B_INIT) ? '0 : psum_q + PW'(y_q);

  always_ff @(posedge clk_i) begin
    if (pre_we) pre_mem[pre_wa] <= pre_wd;
    if (state_q == ST_C_RD0) pre_rd_q <= pre_mem[end_q[CW-1:0]];
    else if (state_q == ST_C_RD1) pre_rd_q <= pre_mem[beg_q[CW-1:0]];
  end

  assign ry = hin_q ? log_rd_q : '0;
  assign rn = hin_q ? noise_rd_q : '0;

  assign res_valid_o          = (state_q == ST_RD_OUT);
  assign res_o.bin_index      = hb_q;
  assign res_o.suppressed     = (ry > rn) ? ry - rn : '0;
  assign res_o.noise_level    = rn;
  assign res_o.saturated      = hin_q & sat_rd_q;

endmodule

### rtl/spectral_noise_suppression_top.sv
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: magnitude, bin; tuser: mode; tlast: last
// m_axis    out  m_axis_tvalid/tready        tdata: bin_index, suppressed, noise_level, saturated
// apb       in   psel, penable, pwrite       paddr/pwdata -> low_bin, high_bin, min_half_band
//
// A load writes the bin memory; a read goes through the memory read registers to the output register.
// The item marked last runs the frame pass: per level bin a check and 22 cube-root bits
// of three multiplies and a compare, then the band mean and its cube, then per bin the
// log (a divide, normalize shifts and 24 squarings; a direct value at zero level) and the
// noise mean (zero if its band is empty).
// Shared multiplier and divider; s_axis_tready low during the pass; async active-low reset.
module spectral_noise_suppression_top #(
  parameter int unsigned MAX_BINS     = sns_pkg::MAX_BINS_DEF,
  parameter int unsigned SAMPLE_WIDTH = sns_pkg::SAMPLE_WIDTH_DEF,
  localparam int unsigned IN_TW = ((SAMPLE_WIDTH + sns_pkg::BIN_W + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_TW-1:0]              s_axis_tdata,  // magnitude, bin, zero pad
  input  logic                          s_axis_tlast,
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sns_pkg::OUT_TW-1:0]    m_axis_tdata,  // bin_index, suppressed,
                                                       // noise_level, saturated, pad
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sns_pkg::PADDR_W-1:0]   paddr,
  input  logic [sns_pkg::PDATA_W-1:0]   pwdata,
  output logic [sns_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import sns_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t out_q;
  logic out_v_q;
  logic res_valid;
  logic res_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_bin       <= 10'd0;
      cfg_q.high_bin      <= 11'd1;
      cfg_q.min_half_band <= 10'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_LOW_BIN:  cfg_q.low_bin       <= pwdata[9:0];
        REG_HIGH_BIN: cfg_q.high_bin      <= pwdata[10:0];
        REG_MIN_HALF: cfg_q.min_half_band <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LOW_BIN:  prdata = PDATA_W'(cfg_q.low_bin);
      REG_HIGH_BIN: prdata = PDATA_W'(cfg_q.high_bin);
      REG_MIN_HALF: prdata = PDATA_W'(cfg_q.min_half_band);
      default:      prdata = '0;
    endcase
  end

  sns_core #(
    .MAX_BINS     (MAX_BINS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_mode_i   (s_axis_tuser),
    .in_mag_i    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .in_last_i   (s_axis_tlast),
    .in_bin_i    (s_axis_tdata[SAMPLE_WIDTH +: BIN_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register: loads go on while a result waits here
  assign res_ready = !out_v_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_TW'({out_q.saturated, out_q.noise_level,
                                  out_q.suppressed, out_q.bin_index});

endmodule

### dv/spectral_noise_suppression_top_test.sv
module spectral_noise_suppression_top_test;
  import sns_pkg::*;

  localparam int unsigned NBINS     = 1024;
  localparam int unsigned CYC_LIMIT = 4000000;
  localparam int unsigned ITEMS     = 2000;

  typedef struct {
    bit         mode;
    logic [31:0] mag;
    bit         last;
    logic [9:0] bin;
    bit         typed;
    res_t       exp;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [OUT_TW-1:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic        pready;

  spectral_noise_suppression_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  cfg_t        mdl_cfg;
  logic [63:0] spec_mag [NBINS];
  logic [23:0] log_mag [NBINS];
  logic [33:0] log_sum [NBINS+1];
  logic [23:0] noise_avg [NBINS];
  bit          sat_flag [NBINS];
  int unsigned frame_len;
  logic [31:0] band_g;
  int unsigned max_seen;  // bins 0..max_seen-1 hold processed results

  res_t        want_q [$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned idle_pct;
  int unsigned stall_pct;

  function automatic logic [63:0] cube_rt(logic [63:0] a);
    logic [63:0] r, t;
    r = '0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t <= 64'(CBRT_MAX) && t * t * t <= a) r = t;
    end
    return r;
  endfunction

  function automatic logic [23:0] ln_fix(logic [63:0] v);
    int p;
    logic [63:0] z, frac, l, y;
    p = 63;
    frac = '0;
    while (p > 0 && !v[p]) p--;
    z = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
    for (int k = 1; k <= 24; k++) begin
      z = (z * z) >> 31;
      if (z >= (64'd1 << 32)) begin
        z = z >> 1;
        frac = frac | (64'd1 << (24 - k));
      end
    end
    l = (64'(p - 16) << 24) | frac;
    y = (l * 64'(LN2_Q32) + (64'd1 << 39)) >> 40;
    return (y > 64'(LOG_MAX)) ? LOG_MAX : y[23:0];
  endfunction

  task automatic run_frame_pass();
    int unsigned n, lo, hi, mh, hu, ho, bg, en;
    logic [63:0] acc, m, x, v;
    logic [23:0] y;
    bit gsat, s;
    n = frame_len;
    lo = mdl_cfg.low_bin;
    hi = mdl_cfg.high_bin;
    mh = mdl_cfg.min_half_band;
    gsat = 0;
    acc = '0;
    if (hi > lo) begin
      for (int unsigned i = lo; i < hi && i < n; i++) acc += cube_rt(spec_mag[i] << 32);
      m = acc / 64'(hi - lo + 1);
      if (m > 64'(CBRT_MAX)) begin
        band_g = 32'hFFFFFFFF;
        gsat = 1;
      end else begin
        band_g = 32'((m * m * m) >> 32);
      end
    end else begin
      band_g = '0;
    end
    log_sum[0] = '0;
    for (int unsigned i = 0; i < n; i++) begin
      x = spec_mag[i];
      s = gsat;
      if (band_g == 0) begin
        y = (x != 0) ? LOG_MAX : 24'd0;
        if (x != 0) s = 1;
      end else begin
        v = 64'd65536 + (x << 16) / 64'(band_g);
        y = ln_fix(v);
        if (y == LOG_MAX) s = 1;
      end
      log_mag[i] = y;
      sat_flag[i] = s;
      log_sum[i+1] = log_sum[i] + 34'(y);
    end
    for (int unsigned i = 0; i < n; i++) begin
      hu = (2 * i) / 3;
      ho = (3 * i) / 2;
      if (hu < mh) hu = mh;
      if (ho < mh) ho = mh;
      bg = (i > hu) ? i - hu : 0;
      en = i + ho;
      if (en > n - 1) en = n - 1;
      if (en > bg) noise_avg[i] = 24'((log_sum[en] - log_sum[bg]) / 34'(en - bg));
      else noise_avg[i] = '0;
    end
    if (n > max_seen) max_seen = n;
  endtask

  // updates the predictor for one accepted item; returns 1 with a result on a read
  task automatic predict_item(input bit mode, input logic [31:0] mag, input bit last,
                              input logic [9:0] bin, output bit has_res, output res_t res);
    has_res = 0;
    res = '0;
    if (!mode) begin
      if (frame_len < NBINS) begin
        spec_mag[frame_len] = 64'(mag);
        frame_len++;
      end
      if (last) begin
        if (frame_len > 0) run_frame_pass();
        frame_len = 0;
      end
    end else begin
      has_res = 1;
      res.bin_index = bin;
      res.suppressed = (log_mag[bin] > noise_avg[bin]) ? log_mag[bin] - noise_avg[bin] : '0;
      res.noise_level = noise_avg[bin];
      res.saturated = sat_flag[bin];
    end
  endtask

  task automatic send_item(input bit mode, input logic [31:0] mag, input bit last,
                           input logic [9:0] bin, input bit typed, input res_t typed_res);
    bit has_res;
    res_t res;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, bin, mag};
    s_axis_tuser <= mode;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predict_item(mode, mag, last, bin, has_res, res);
    if (has_res) want_q = {want_q, (typed ? typed_res : res)};
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LOW_BIN:  mdl_cfg.low_bin = val[9:0];
      REG_HIGH_BIN: mdl_cfg.high_bin = val[10:0];
      REG_MIN_HALF: mdl_cfg.min_half_band = val[9:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_mag();
    int unsigned k;
    k = $urandom_range(9);
    case (k)
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2, 3: return $urandom_range(32'hFFFF);
      4: return $urandom_range(32'hFFFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] rand_bin(int unsigned hint);
    if (hint > 0 && $urandom_range(3) != 0) return 10'($urandom_range(hint - 1));
    return 10'($urandom_range(max_seen - 1));
  endfunction

  // results and receiver stalls
  always @(posedge clk_i) begin
    res_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (want_q.size() == 0) begin
        $error("unexpected result item, tdata %h", m_axis_tdata);
        errors++;
      end else begin
        w = want_q.pop_front();
        if (m_axis_tdata[9:0] !== w.bin_index) begin
          $error("bin_index: expected %0d, actual %0d", w.bin_index, m_axis_tdata[9:0]);
          errors++;
        end
        if (m_axis_tdata[33:10] !== w.suppressed) begin
          $error("suppressed: expected %h, actual %h", w.suppressed, m_axis_tdata[33:10]);
          errors++;
        end
        if (m_axis_tdata[57:34] !== w.noise_level) begin
          $error("noise_level: expected %h, actual %h", w.noise_level, m_axis_tdata[57:34]);
          errors++;
        end
        if (m_axis_tdata[58] !== w.saturated) begin
          $error("saturated: expected %b, actual %b", w.saturated, m_axis_tdata[58]);
          errors++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  dir_row_t dir_tab [14];
  int unsigned cfg_tab [7][3];

  initial begin
    int unsigned done, budget, n;
    bit lst;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    frame_len = 0;
    band_g = '0;
    max_seen = 0;
    mdl_cfg = '{low_bin: 10'd0, high_bin: 11'd1, min_half_band: 10'd1};
    // zero level: a zero bin reads back zeros, a nonzero bin saturates
    dir_tab = '{
      '{0, 32'd0, 1, 10'd0, 0, '0},
      '{1, 32'd0, 0, 10'd0, 1, '{10'd0, 24'd0, 24'd0, 1'b0}},
      '{0, 32'd5, 1, 10'd1023, 0, '0},
      '{1, 32'hFFFFFFFF, 1, 10'd0, 1, '{10'd0, 24'hFFFFFF, 24'd0, 1'b1}},
      '{0, 32'hFFFFFFFF, 0, 10'd0, 0, '0},
      '{0, 32'd0, 0, 10'd0, 0, '0},
      '{0, 32'd1, 0, 10'd0, 0, '0},
      '{0, 32'h10000, 0, 10'd0, 0, '0},
      '{0, 32'h80000000, 1, 10'd0, 0, '0},
      '{1, 32'd0, 0, 10'd0, 0, '0},
      '{1, 32'd0, 0, 10'd1, 0, '0},
      '{1, 32'd0, 0, 10'd2, 0, '0},
      '{1, 32'd0, 0, 10'd3, 0, '0},
      '{1, 32'd0, 0, 10'd4, 0, '0}
    };
    // low, high, min half band; includes extremes and an inverted band
    cfg_tab = '{'{0, 1, 1}, '{0, 1024, 0}, '{1023, 1024, 1023}, '{5, 3, 2},
                '{0, 8, 3}, '{2, 40, 1}, '{0, 0, 0}};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_item(dir_tab[i].mode, dir_tab[i].mag, dir_tab[i].last, dir_tab[i].bin,
                dir_tab[i].typed, dir_tab[i].exp);

    done = 0;
    for (int p = 0; p < 7; p++) begin
      drain();
      if (p == 6) begin
        cfg_tab[6][0] = $urandom_range(1023);
        cfg_tab[6][1] = $urandom_range(1, 1024);
        cfg_tab[6][2] = $urandom_range(1023);
      end
      reg_write(REG_LOW_BIN, cfg_tab[p][0]);
      reg_write(REG_HIGH_BIN, cfg_tab[p][1]);
      reg_write(REG_MIN_HALF, cfg_tab[p][2]);
      @(posedge clk_i);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      if (p == 1) begin
        // full frame: one load past the end is dropped but still closes the frame
        for (int k = 0; k < NBINS + 1; k++) begin
          send_item(0, rand_mag(), k == NBINS, 10'($urandom), 0, '0);
          done++;
        end
        repeat (40) begin
          send_item(1, $urandom, $urandom_range(1), 10'($urandom), 0, '0);
          done++;
        end
      end
      budget = done + (ITEMS - 14 - 1025) / 7;
      while (done < budget) begin
        n = ($urandom_range(99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 64);
        for (int unsigned k = 0; k < n; k++) begin
          if (max_seen > 0 && $urandom_range(99) < 8) begin
            send_item(1, $urandom, $urandom_range(1), rand_bin(0), 0, '0);
            done++;
          end
          lst = (k == n - 1);
          send_item(0, rand_mag(), lst, 10'($urandom), 0, '0);
          done++;
        end
        repeat ($urandom_range(1, 8)) begin
          send_item(1, $urandom, $urandom_range(1), rand_bin(n), 0, '0);
          done++;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
